@@ hw/rtl/rcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared types, constants and the curve helper of the differential drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

	localparam int unsigned PULSE_TIMEOUT_US = 20000;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned DIV_STEPS        = 14;
	localparam int unsigned CNT_W            = $clog2(DIV_STEPS);

	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned ADDR_W   = 5;

	localparam logic [2:0] REG_STEER_MIN = 3'd0;
	localparam logic [2:0] REG_STEER_MAX = 3'd1;
	localparam logic [2:0] REG_SPEED_MIN = 3'd2;
	localparam logic [2:0] REG_SPEED_MAX = 3'd3;
	localparam logic [2:0] REG_DEADZONE  = 3'd4;
	localparam logic [2:0] REG_PRELOAD   = 3'd5;

	localparam logic [14:0] RST_STEER_MIN = 15'd1075;
	localparam logic [14:0] RST_STEER_MAX = 15'd1800;
	localparam logic [14:0] RST_SPEED_MIN = 15'd1041;
	localparam logic [14:0] RST_SPEED_MAX = 15'd1856;
	localparam logic [11:0] RST_DEADZONE  = 12'd250;
	localparam logic [7:0]  RST_PRELOAD   = 8'd110;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_BWD  = 2'b10;

	// floor(256 * 2^(r/32))
	localparam logic [8:0] CURVE_FRAC [32] = '{
		9'd256, 9'd261, 9'd267, 9'd273, 9'd279, 9'd285, 9'd291, 9'd297,
		9'd304, 9'd311, 9'd317, 9'd324, 9'd331, 9'd339, 9'd346, 9'd354,
		9'd362, 9'd369, 9'd378, 9'd386, 9'd394, 9'd403, 9'd412, 9'd421,
		9'd430, 9'd439, 9'd449, 9'd459, 9'd469, 9'd479, 9'd490, 9'd501
	};

	typedef struct packed {
		logic [14:0] steer_min_us;
		logic [14:0] steer_max_us;
		logic [14:0] speed_min_us;
		logic [14:0] speed_max_us;
		logic [11:0] stick_deadzone;
		logic [7:0]  motor_preload;
	} rcpd_cfg_t;

	typedef struct packed {
		logic [14:0] steer_pulse_us;
		logic [14:0] speed_pulse_us;
		logic        apply;
	} rcpd_item_t;

	typedef struct packed {
		logic       applied;
		logic       right_bwd;
		logic       right_fwd;
		logic [7:0] right_duty;
		logic       left_bwd;
		logic       left_fwd;
		logic [7:0] left_duty;
	} rcpd_result_t;

	typedef struct packed {
		logic [7:0] mag;
		logic [1:0] dir;
	} rcpd_wheel_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SETUP,
		BK_DIV,
		BK_POST,
		BK_SCALE,
		BK_CURVE,
		BK_DUTY_MUL,
		BK_DUTY_DIV,
		BK_OUT
	} rcpd_state_t;

	// exponential curve on a mixed wheel value, capped at 255 either way
	function automatic rcpd_wheel_t rcpd_curve(input logic signed [9:0] w);
		logic        pos;
		logic [9:0]  neg_w;
		logic [7:0]  a;
		logic [8:0]  f;
		logic [9:0]  s;
		rcpd_wheel_t res;
		pos   = (w > 10'sd0);
		neg_w = 10'(-w);
		if (w > 10'sd255 || w < -10'sd255) begin
			a = 8'd255;
		end else if (pos) begin
			a = w[7:0];
		end else begin
			a = neg_w[7:0];
		end
		f = CURVE_FRAC[a[4:0]] >> (3'd7 - a[7:5]);
		if (pos) begin
			s = 10'(f) + 10'd2;
		end else begin
			s = 10'(f) - 10'd2;
		end
		res.mag = (s > 10'd255) ? 8'd255 : s[7:0];
		if (pos) begin
			res.dir = DIR_FWD;
		end else if (s == 10'd0) begin
			res.dir = DIR_NONE;
		end else begin
			res.dir = DIR_BWD;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rcpd_front.sv @@
// ----------------------------------------------------------------------------
// rcpd_front
// Unpacks an input beat and marks whether it drives the wheels or repeats.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_front (
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [31:0]         s_tdata,
	input  wire logic                q_full,
	output logic                     q_push,
	output rcpd_pkg::rcpd_item_t     q_item
);
	import rcpd_pkg::*;

	logic [14:0] steer;
	logic [14:0] speed;
	logic        live;

	assign steer = s_tdata[14:0];
	assign speed = s_tdata[29:15];
	assign live  = s_tdata[30];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.steer_pulse_us = steer;
		q_item.speed_pulse_us = speed;
		q_item.apply = live && (steer != 15'd0) && (speed != 15'd0)
			&& (17'(steer) <= 17'(PULSE_TIMEOUT_US))
			&& (17'(speed) <= 17'(PULSE_TIMEOUT_US));
	end

endmodule

`default_nettype wire

@@ hw/rtl/rcpd_queue.sv @@
// ----------------------------------------------------------------------------
// rcpd_queue
// Short queue between the front and the back of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire rcpd_pkg::rcpd_item_t wr_item,
	output logic                     full,
	input  wire logic                pop,
	output logic                     valid,
	output rcpd_pkg::rcpd_item_t     rd_item
);
	import rcpd_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

	rcpd_item_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_QW-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rcpd_back.sv @@
// ----------------------------------------------------------------------------
// rcpd_back
// Maps both sticks through a shared divider, mixes, shapes and sets the duty.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rcpd_pkg::rcpd_cfg_t  cfg,
	input  wire logic                 q_valid,
	input  wire rcpd_pkg::rcpd_item_t q_item,
	output logic                      q_pop,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output rcpd_pkg::rcpd_result_t    res
);
	import rcpd_pkg::*;

	rcpd_state_t        state_q;
	rcpd_state_t        state_d;
	logic               out_load;

	rcpd_item_t         item_q;
	logic               chan_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [27:0]        num_q;
	logic [15:0]        rem_q;
	logic [14:0]        den_q;
	logic               neg_q;
	logic               eq_q;
	logic signed [12:0] capped_q;
	logic signed [8:0]  steer_q;
	logic signed [8:0]  speed_q;
	rcpd_wheel_t        lw_q;
	rcpd_wheel_t        rw_q;
	logic [15:0]        lx_q;
	logic [15:0]        rx_q;
	logic [7:0]         held_ld_q;
	logic [1:0]         held_ldir_q;
	logic [7:0]         held_rd_q;
	logic [1:0]         held_rdir_q;
	rcpd_result_t       out_q;
	logic               out_valid_q;

	// setup
	logic [14:0]        pulse;
	logic [14:0]        lo;
	logic [14:0]        hi;
	logic signed [15:0] diff;
	logic signed [15:0] span;
	logic [14:0]        dmag;
	logic [14:0]        smag;
	logic [27:0]        nprod;

	// divider, two bits a cycle
	logic [15:0]        r_a;
	logic [15:0]        r_b;
	logic [27:0]        n_a;
	logic [27:0]        n_b;

	// post
	logic signed [29:0] qs;
	logic signed [29:0] v;
	logic signed [29:0] dz;
	logic signed [29:0] vd;
	logic signed [12:0] capped;

	// scale
	logic [11:0]        cmag;
	logic [24:0]        sprod;
	logic [7:0]         q10;
	logic signed [8:0]  stick;

	// mix
	logic signed [9:0]  sp;
	logic signed [9:0]  st;
	logic signed [9:0]  lmix;
	logic signed [9:0]  rmix;

	// duty
	logic [7:0]         span_p;
	logic [31:0]        lp;
	logic [31:0]        rp;
	logic [7:0]         ld;
	logic [7:0]         rd;

	always_comb begin
		pulse = chan_q ? item_q.speed_pulse_us : item_q.steer_pulse_us;
		lo    = chan_q ? cfg.speed_min_us : cfg.steer_min_us;
		hi    = chan_q ? cfg.speed_max_us : cfg.steer_max_us;
		diff  = $signed({1'b0, pulse}) - $signed({1'b0, lo});
		span  = $signed({1'b0, hi}) - $signed({1'b0, lo});
		dmag  = diff[15] ? 15'(-diff) : diff[14:0];
		smag  = span[15] ? 15'(-span) : span[14:0];
		nprod = 28'(dmag) * 28'(13'd5200);
	end

	always_comb begin
		r_a = {rem_q[14:0], num_q[27]};
		n_a = {num_q[26:0], 1'b0};
		if (r_a >= {1'b0, den_q}) begin
			r_a    = r_a - {1'b0, den_q};
			n_a[0] = 1'b1;
		end
		r_b = {r_a[14:0], n_a[27]};
		n_b = {n_a[26:0], 1'b0};
		if (r_b >= {1'b0, den_q}) begin
			r_b    = r_b - {1'b0, den_q};
			n_b[0] = 1'b1;
		end
	end

	always_comb begin
		qs = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		dz = $signed({18'd0, cfg.stick_deadzone});
		v  = eq_q ? 30'sd0 : qs - 30'sd2600;
		if ((v < dz) && (v > -dz)) begin
			vd = 30'sd0;
		end else if (v < dz) begin
			vd = v + dz;
		end else begin
			vd = v - dz;
		end
		if (vd > 30'sd2550) begin
			capped = 13'sd2550;
		end else if (vd < -30'sd2550) begin
			capped = -13'sd2550;
		end else begin
			capped = vd[12:0];
		end
	end

	always_comb begin
		cmag  = capped_q[12] ? 12'(-capped_q) : 12'(capped_q);
		sprod = 25'(cmag) * 25'(13'd6554);
		q10   = sprod[23:16];
		stick = capped_q[12] ? -$signed({1'b0, q10}) : $signed({1'b0, q10});
	end

	always_comb begin
		sp   = {speed_q[8], speed_q};
		st   = {steer_q[8], steer_q};
		lmix = sp + st;
		rmix = sp - st;
		if (sp > 10'sd0) begin
			if (lmix > sp) begin
				lmix = sp;
			end
			if (rmix > sp) begin
				rmix = sp;
			end
		end
		if (sp < 10'sd0) begin
			if (lmix < sp) begin
				lmix = sp;
			end
			if (rmix < sp) begin
				rmix = sp;
			end
		end
	end

	// x / 255 as (x * 32897) >> 23, exact for 16-bit x
	always_comb begin
		span_p = 8'd255 - cfg.motor_preload;
		lp     = 32'(lx_q) * 32'(17'd32897);
		rp     = 32'(rx_q) * 32'(17'd32897);
		ld     = lp[30:23] + cfg.motor_preload;
		rd     = rp[30:23] + cfg.motor_preload;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = q_item.apply ? BK_SETUP : BK_OUT;
				end
			end
			BK_SETUP:    state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = BK_POST;
				end
			end
			BK_POST:     state_d = BK_SCALE;
			BK_SCALE:    state_d = chan_q ? BK_CURVE : BK_SETUP;
			BK_CURVE:    state_d = BK_DUTY_MUL;
			BK_DUTY_MUL: state_d = BK_DUTY_DIV;
			BK_DUTY_DIV: state_d = BK_OUT;
			BK_OUT: begin
				if (!out_valid_q || res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: q_pop    = q_valid;
			BK_OUT:  out_load = !out_valid_q || res_ready;
			default: begin
				q_pop    = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			chan_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			held_ld_q   <= '0;
			held_ldir_q <= DIR_NONE;
			held_rd_q   <= '0;
			held_rdir_q <= DIR_NONE;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE:  chan_q <= 1'b0;
				BK_SETUP: cnt_q  <= '0;
				BK_DIV:   cnt_q  <= cnt_q + 1'b1;
				BK_SCALE: chan_q <= 1'b1;
				BK_DUTY_DIV: begin
					held_ld_q   <= (lw_q.dir == DIR_NONE) ? 8'd255 : ld;
					held_ldir_q <= lw_q.dir;
					held_rd_q   <= (rw_q.dir == DIR_NONE) ? 8'd0 : rd;
					held_rdir_q <= rw_q.dir;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					item_q <= q_item;
				end
			end
			BK_SETUP: begin
				num_q <= nprod;
				rem_q <= '0;
				den_q <= smag;
				neg_q <= diff[15] ^ span[15];
				eq_q  <= (lo == hi);
			end
			BK_DIV: begin
				num_q <= n_b;
				rem_q <= r_b;
			end
			BK_POST: capped_q <= capped;
			BK_SCALE: begin
				if (chan_q) begin
					speed_q <= stick;
				end else begin
					steer_q <= stick;
				end
			end
			BK_CURVE: begin
				lw_q <= rcpd_curve(lmix);
				rw_q <= rcpd_curve(rmix);
			end
			BK_DUTY_MUL: begin
				lx_q <= 16'(lw_q.mag) * 16'(span_p);
				rx_q <= 16'(rw_q.mag) * 16'(span_p);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.left_duty  <= held_ld_q;
			out_q.left_fwd   <= held_ldir_q[0];
			out_q.left_bwd   <= held_ldir_q[1];
			out_q.right_duty <= held_rd_q;
			out_q.right_fwd  <= held_rdir_q[0];
			out_q.right_bwd  <= held_rdir_q[1];
			out_q.applied    <= item_q.apply;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/rc_pulse_to_differential_drive.sv @@
// ----------------------------------------------------------------------------
// rc_pulse_to_differential_drive
// Turns steering and speed pulse widths into left and right bridge drive.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata and carry both pulse widths
// and the live flag of the other receiver channels. Result beats leave on
// m_tvalid/m_tready/m_tdata with the "applied" flag on m_tuser. Every input
// beat gives exactly one result beat, in order.
// A beat that drives the wheels passes setup, divide, post and scale for the
// steering stick and then the speed stick, then curve, duty multiply and duty
// divide before it reaches the output stage; a beat that only repeats the held
// outputs goes straight to the output stage. The back end handles one beat at a
// time, and the shared two-bit-per-cycle divider maps both sticks in turn.
// A two-entry queue sits behind s_tready, so the source can run ahead while
// the back end works or while m_tready is low; a finished result waits in
// the output register until taken.
// Reset clears the held drive to zero, both lines low, and loads the
// calibration registers with their defaults. Registers sit on the APB port
// at byte address 4*index and should only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_to_differential_drive (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// steer_pulse_us[14:0], speed_pulse_us[29:15], other_channels_live[30]
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [31:0]                s_tdata,
	// left_duty[7:0], left_fwd[8], left_bwd[9], right_duty[17:10],
	// right_fwd[18], right_bwd[19]
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [23:0]                     m_tdata,
	// applied[0]
	output logic                            m_tuser,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rcpd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import rcpd_pkg::*;

	rcpd_cfg_t    cfg_q;
	logic [2:0]   reg_idx;
	logic         cfg_wr;
	logic         q_full;
	logic         q_push;
	rcpd_item_t   wr_item;
	logic         q_valid;
	logic         q_pop;
	rcpd_item_t   rd_item;
	rcpd_result_t res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_min_us   <= RST_STEER_MIN;
			cfg_q.steer_max_us   <= RST_STEER_MAX;
			cfg_q.speed_min_us   <= RST_SPEED_MIN;
			cfg_q.speed_max_us   <= RST_SPEED_MAX;
			cfg_q.stick_deadzone <= RST_DEADZONE;
			cfg_q.motor_preload  <= RST_PRELOAD;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_STEER_MIN: cfg_q.steer_min_us   <= pwdata[14:0];
				REG_STEER_MAX: cfg_q.steer_max_us   <= pwdata[14:0];
				REG_SPEED_MIN: cfg_q.speed_min_us   <= pwdata[14:0];
				REG_SPEED_MAX: cfg_q.speed_max_us   <= pwdata[14:0];
				REG_DEADZONE:  cfg_q.stick_deadzone <= pwdata[11:0];
				REG_PRELOAD:   cfg_q.motor_preload  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STEER_MIN: prdata = 32'(cfg_q.steer_min_us);
			REG_STEER_MAX: prdata = 32'(cfg_q.steer_max_us);
			REG_SPEED_MIN: prdata = 32'(cfg_q.speed_min_us);
			REG_SPEED_MAX: prdata = 32'(cfg_q.speed_max_us);
			REG_DEADZONE:  prdata = 32'(cfg_q.stick_deadzone);
			REG_PRELOAD:   prdata = 32'(cfg_q.motor_preload);
			default:       prdata = '0;
		endcase
	end

	rcpd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (wr_item)
	);

	rcpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_item (rd_item)
	);

	rcpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (rd_item),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {4'd0, res.right_bwd, res.right_fwd, res.right_duty,
		res.left_bwd, res.left_fwd, res.left_duty};
	assign m_tuser = res.applied;

endmodule

`default_nettype wire
